// File: hw/rtl/shmm_pkg.sv
// Shared types, opcodes and constants for the seed hit match merger.
package shmm_pkg;

	localparam int COORD_W     = 32;
	localparam int SEED_W      = 6;
	localparam int MAX_RESULTS = 16;
	localparam int K_W         = $clog2(MAX_RESULTS + 1);
	localparam int IN_DATA_W   = 160;
	localparam int OUT_DATA_W  = 168;
	localparam logic [SEED_W-1:0] SEED_RESET = 6'd30;

	localparam logic [2:0] OP_NOP   = 3'd0;
	localparam logic [2:0] OP_WIDEN = 3'd1;
	localparam logic [2:0] OP_LOAD  = 3'd2;
	localparam logic [2:0] OP_SORT  = 3'd3;
	localparam logic [2:0] OP_DEDUP = 3'd4;
	localparam logic [2:0] OP_SHIFT = 3'd5;

	typedef struct packed {
		logic [COORD_W-1:0] qs;
		logic [COORD_W-1:0] qe;
		logic [COORD_W-1:0] rs;
		logic [COORD_W-1:0] re;
	} span_t;

	typedef struct packed {
		logic  v;
		span_t s;
	} entry_t;

	typedef struct packed {
		logic [2:0] op;
		logic       pair_left;
		logic       pair_right;
		span_t      h;
	} cell_ctrl_t;

endpackage

// File: hw/rtl/shmm_cell.sv
// One open-match cell of the chain: widen, load, sort swap, dedup and shift.
module shmm_cell import shmm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  entry_t     left_e,
	input  entry_t     right_e,
	input  logic       left_swap,
	output entry_t     self_e,
	output logic       swap,
	output logic       hit
);

	logic  v_q;
	span_t s_q;

	// invalid entries order after every valid one
	function automatic logic greater(entry_t a, entry_t b);
		logic r;
		begin
			r = 1'b0;
			if (a.v != b.v) begin
				r = !a.v;
			end else if (a.v) begin
				if (a.s.re != b.s.re)      r = a.s.re > b.s.re;
				else if (a.s.qs != b.s.qs) r = a.s.qs > b.s.qs;
				else if (a.s.qe != b.s.qe) r = a.s.qe > b.s.qe;
				else                       r = a.s.rs > b.s.rs;
			end
			return r;
		end
	endfunction

	assign self_e = '{v: v_q, s: s_q};
	assign swap   = ctrl.pair_left && greater(self_e, right_e);
	assign hit    = v_q && (s_q.qs <= ctrl.h.qs) && (ctrl.h.qs <= s_q.qe)
		&& (s_q.rs <= ctrl.h.rs) && (ctrl.h.rs <= s_q.re);

	logic dup;
	assign dup = v_q && left_e.v && (left_e.s.qe == s_q.qe) && (left_e.s.re == s_q.re);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				OP_LOAD: v_q <= 1'b1;
				OP_SORT: begin
					if (swap) v_q <= right_e.v;
					else if (ctrl.pair_right && left_swap) v_q <= left_e.v;
				end
				OP_DEDUP: if (dup) v_q <= 1'b0;
				OP_SHIFT: v_q <= right_e.v;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_WIDEN: begin
				if (hit) begin
					if (ctrl.h.qe > s_q.qe) s_q.qe <= ctrl.h.qe;
					if (ctrl.h.re > s_q.re) s_q.re <= ctrl.h.re;
				end
			end
			OP_LOAD: s_q <= ctrl.h;
			OP_SORT: begin
				if (swap) s_q <= right_e.s;
				else if (ctrl.pair_right && left_swap) s_q <= left_e.s;
			end
			OP_SHIFT: s_q <= right_e.s;
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/seed_hit_match_merger_unit.sv
// Top level: chain of match cells with control sequencer and result staging.
// Hit: accept, widen, insert, odd-even sort, dedup, drain through the head cell, finish.
// Flush: accept, drain through the head cell, finish.
// One item at a time; drain and finish stall while the output register is held, and the
// last result of an item may wait there while the next item enters.
// Reset: table empty, current reference and overflow flag zero, seed length 30.
module seed_hit_match_merger_unit import shmm_pkg::*; #(
	parameter int OPEN_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [SEED_W-1:0]     cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// reference id, query_start, query_last, ref_start, ref_last
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// match_ref, match_query_start, match_query_end, match_ref_start,
	// match_ref_end, overflowed, zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// has_match
	output logic                  m_axis_tuser,
	// last_of_run
	output logic                  m_axis_tlast
);

	localparam int NCELL  = OPEN_DEPTH + 1;
	localparam int STEP_W = $clog2(NCELL + 1);
	localparam int CNT_W  = $clog2(OPEN_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WIDEN = 3'd1;
	localparam logic [2:0] ST_INS   = 3'd2;
	localparam logic [2:0] ST_SORT  = 3'd3;
	localparam logic [2:0] ST_DEDUP = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]          state_q;
	logic [STEP_W-1:0]   step_q;
	logic [K_W-1:0]      k_q;
	logic [CNT_W-1:0]    kept_q;
	logic [CNT_W-1:0]    count_q;
	logic [SEED_W-1:0]   seed_len_q;
	logic [COORD_W-1:0]  cur_ref_q;
	logic                ovf_q;
	logic                flush_q;
	logic                added_q;
	span_t               h_q;
	logic                pend_v_q;
	span_t               pend_q;
	logic                out_v_q;
	logic                out_has_q;
	logic                out_last_q;
	logic                out_ovf_q;
	logic [COORD_W-1:0]  out_ref_q;
	span_t               out_span_q;

	entry_t     cell_e    [NCELL];
	logic       cell_swap [NCELL];
	logic       cell_hit  [NCELL];
	cell_ctrl_t cell_ctrl [NCELL];
	entry_t     push_e;
	logic [2:0] table_op;
	logic [2:0] spare_op;
	logic       any_hit;
	entry_t     head;
	logic       want_emit;
	logic       out_free;
	logic       out_load;
	logic       advance;
	logic       do_insert;
	span_t      h_in;

	function automatic logic [COORD_W-1:0] end_of(logic [COORD_W-1:0] last,
		logic [SEED_W-1:0] len);
		logic [COORD_W:0] sum;
		begin
			sum = {1'b0, last} + {{(COORD_W + 1 - SEED_W){1'b0}}, len};
			return sum[COORD_W] ? {COORD_W{1'b1}} : sum[COORD_W-1:0];
		end
	endfunction

	assign h_in.qs = s_axis_tdata[63:32];
	assign h_in.qe = end_of(s_axis_tdata[95:64], seed_len_q);
	assign h_in.rs = s_axis_tdata[127:96];
	assign h_in.re = end_of(s_axis_tdata[159:128], seed_len_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !out_v_q || m_axis_tready;
	assign head          = cell_e[0];
	assign want_emit     = head.v && (flush_q || (head.s.qe < h_q.qs))
		&& (k_q < K_W'(MAX_RESULTS));
	assign advance       = (state_q == ST_DRAIN) && (!want_emit || !pend_v_q || out_free);
	assign push_e        = (head.v && !want_emit) ? head : '0;
	assign do_insert     = (state_q == ST_INS) && !added_q
		&& (count_q != CNT_W'(OPEN_DEPTH));
	// a transaction enters the output register
	assign out_load      = (advance && want_emit && pend_v_q)
		|| ((state_q == ST_FIN) && out_free && (pend_v_q || (flush_q && k_q == '0)));

	always_comb begin
		table_op = OP_NOP;
		unique case (state_q)
			ST_WIDEN: table_op = OP_WIDEN;
			ST_SORT:  table_op = OP_SORT;
			ST_DEDUP: table_op = OP_DEDUP;
			ST_DRAIN: table_op = advance ? OP_SHIFT : OP_NOP;
			default:  table_op = OP_NOP;
		endcase
		spare_op = do_insert ? OP_LOAD : table_op;
	end

	always_comb begin
		any_hit = 1'b0;
		for (int i = 0; i < NCELL; i++) any_hit = any_hit | cell_hit[i];
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		localparam logic ODD = (i % 2) == 1;
		entry_t left_e;
		entry_t right_e;
		logic   left_swap;

		if (i == 0) begin : g_first
			assign left_e    = '0;
			assign left_swap = 1'b0;
		end else begin : g_mid
			assign left_e    = cell_e[i-1];
			assign left_swap = cell_swap[i-1];
		end
		if (i == NCELL - 1) begin : g_last
			assign right_e                = push_e;
			assign cell_ctrl[i].op        = spare_op;
			assign cell_ctrl[i].pair_left = 1'b0;
		end else begin : g_inner
			assign right_e                = cell_e[i+1];
			assign cell_ctrl[i].op        = table_op;
			assign cell_ctrl[i].pair_left = (step_q[0] == ODD);
		end
		assign cell_ctrl[i].pair_right = (i > 0) && (step_q[0] != ODD);
		assign cell_ctrl[i].h          = h_q;

		shmm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl[i]),
			.left_e   (left_e),
			.right_e  (right_e),
			.left_swap(left_swap),
			.self_e   (cell_e[i]),
			.swap     (cell_swap[i]),
			.hit      (cell_hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			k_q        <= '0;
			kept_q     <= '0;
			count_q    <= '0;
			seed_len_q <= SEED_RESET;
			cur_ref_q  <= '0;
			ovf_q      <= 1'b0;
			flush_q    <= 1'b0;
			added_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_we) seed_len_q <= cfg_wdata;
			out_v_q <= out_load || (out_v_q && !m_axis_tready);
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					k_q    <= '0;
					kept_q <= '0;
					if (s_axis_tvalid) begin
						flush_q <= s_axis_tuser;
						if (s_axis_tuser) begin
							state_q <= ST_DRAIN;
						end else begin
							cur_ref_q <= s_axis_tdata[31:0];
							state_q   <= ST_WIDEN;
						end
					end
				end
				ST_WIDEN: begin
					added_q <= any_hit;
					state_q <= ST_INS;
				end
				ST_INS: begin
					if (!added_q && !do_insert) ovf_q <= 1'b1;
					state_q <= ST_SORT;
				end
				ST_SORT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(NCELL - 1)) state_q <= ST_DEDUP;
				end
				ST_DEDUP: begin
					step_q  <= '0;
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (advance) begin
						step_q <= step_q + 1'b1;
						if (push_e.v) kept_q <= kept_q + 1'b1;
						if (want_emit) begin
							k_q      <= k_q + 1'b1;
							pend_v_q <= 1'b1;
						end
						if (step_q == STEP_W'(NCELL - 1)) begin
							count_q <= kept_q + CNT_W'(push_e.v);
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (pend_v_q) begin
						if (out_free) begin
							pend_v_q <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end else if (flush_q && k_q == '0) begin
						if (out_free) state_q <= ST_IDLE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload of hit, pending result and output stage
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid && !s_axis_tuser) h_q <= h_in;
		if (advance && want_emit) begin
			pend_q <= head.s;
			if (pend_v_q) begin
				out_has_q  <= 1'b1;
				out_last_q <= 1'b0;
				out_ovf_q  <= ovf_q;
				out_ref_q  <= cur_ref_q;
				out_span_q <= pend_q;
			end
		end
		if (state_q == ST_FIN && out_free) begin
			out_last_q <= 1'b1;
			out_ovf_q  <= ovf_q;
			if (pend_v_q) begin
				out_has_q  <= 1'b1;
				out_ref_q  <= cur_ref_q;
				out_span_q <= pend_q;
			end else begin
				out_has_q  <= 1'b0;
				out_ref_q  <= '0;
				out_span_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = out_has_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'b0, out_ovf_q, out_span_q.re, out_span_q.rs,
		out_span_q.qe, out_span_q.qs, out_ref_q};

endmodule

// File: hw/rtl/shmm_check.sv
// Port-level checks for the merger output stream, bound to the top level.
module shmm_check import shmm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser,
	input logic                  m_axis_tlast
);

	logic ovf_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovf_seen_q <= 1'b0;
		else if (m_axis_tvalid && m_axis_tdata[160]) ovf_seen_q <= 1'b1;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction changed while stalled");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("empty flush marker not marked last");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[159:0] == '0)
		else $error("empty flush marker carries coordinates");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ovf_seen_q |-> m_axis_tdata[160])
		else $error("overflow flag dropped after being reported");

endmodule

bind seed_hit_match_merger_unit shmm_check u_shmm_check (.*);
